/* hdl/mpts_pkg.sv */
package mpts_pkg;

    localparam logic [31:0] PAT_WORD   = 32'h5a5a_5a5a;
    localparam logic [31:0] PAT_BYTE   = 32'h0000_00a5;
    localparam logic [31:0] PAT_MERGED = 32'h5a5a_5aa5;

    localparam logic [31:0] BASE_RESET  = 32'h4000_0000;
    localparam logic [31:0] START_RESET = 32'h0000_0000;
    localparam logic [31:0] END_RESET   = 32'h0001_0000;
    localparam logic        ORDER_RESET = 1'b1;
    localparam logic [4:0]  SHIFT_RESET = 5'd20;

    localparam logic [2:0] SRAM_PHASES = 3'd6;
    localparam logic [2:0] DDR_PHASES  = 3'd5;

    localparam logic ORDER_SRAM = 1'b0;
    localparam logic CMD_START  = 1'b0;

    localparam logic [2:0] CFG_BASE  = 3'd0;
    localparam logic [2:0] CFG_START = 3'd1;
    localparam logic [2:0] CFG_END   = 3'd2;
    localparam logic [2:0] CFG_ORDER = 3'd3;
    localparam logic [2:0] CFG_SHIFT = 3'd4;

    typedef enum logic [2:0] {
        K_WPAT,
        K_RPAT,
        K_WBYTE,
        K_RBYTE,
        K_WADDR,
        K_RADDR
    } kind_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [31:0] offset;
        logic        running;
        logic        finished;
    } seq_state_t;

    function automatic kind_t kind_of(logic order, logic [2:0] phase);
        kind_t k;
        k = K_RPAT;
        if (order == ORDER_SRAM)
        begin
            case (phase)
                3'd0:    k = K_WPAT;
                3'd1:    k = K_RPAT;
                3'd2:    k = K_WBYTE;
                3'd3:    k = K_RBYTE;
                3'd4:    k = K_WADDR;
                3'd5:    k = K_RADDR;
                default: k = K_RPAT;
            endcase
        end
        else
        begin
            case (phase)
                3'd0:    k = K_WADDR;
                3'd1:    k = K_RADDR;
                3'd2:    k = K_WPAT;
                3'd3:    k = K_WBYTE;
                3'd4:    k = K_RBYTE;
                default: k = K_RBYTE;
            endcase
        end
        return k;
    endfunction

    // Skips finished phases. After the first skip the offset is the start
    // offset, so one extra compare covers every further skip.
    function automatic seq_state_t settle(seq_state_t s, logic [31:0] start_off,
                                          logic [31:0] end_off, logic [2:0] count);
        seq_state_t r;
        r = s;
        if (s.running)
        begin
            if (s.phase >= count)
            begin
                r.running  = 1'b0;
                r.finished = 1'b1;
            end
            else if (s.offset >= end_off)
            begin
                if (start_off >= end_off || (s.phase + 3'd1) >= count)
                begin
                    r.running  = 1'b0;
                    r.finished = 1'b1;
                end
                else
                begin
                    r.phase  = s.phase + 3'd1;
                    r.offset = start_off;
                end
            end
        end
        return r;
    endfunction

endpackage

/* hdl/memory_pattern_test_sequencer.sv */
// Memory pattern test sequencer.
// Input channel (in_valid/in_ready): cmd 0 starts a new test, cmd 1 reports
// that the access last issued has completed, with read_data for a read.
// Output channel (out_valid/out_ready): one result per input transfer,
// describing the next memory access (access_valid) or the final verdict
// (done_res, passed) with the most recent failing address and data.
// Configuration is written through cfg_we/cfg_index/cfg_data at any edge
// with cfg_we high; registers are read live by the sequencer.
// Results are registered: an input register takes each transfer, then the
// sequencing step writes the result register.
// Throughput is one item per cycle while the receiver takes results; the limit
// is the single step that updates phase, offset and fail record from one item to the next.
// When the receiver stalls, one further item is taken into the input
// register and in_ready then drops until the result is taken.
// Reset clears the sequencer to idle with no verdict and loads the
// configuration defaults (base 0x40000000, range 0 to 0x10000, DDR order,
// progress interval 2^20 bytes).
module memory_pattern_test_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [31:0] read_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        access_valid,
    output logic        is_write,
    output logic        byte_only,
    output logic [31:0] address,
    output logic [31:0] write_data,
    output logic [2:0]  phase,
    output logic        progress_mark,
    output logic        done_res,
    output logic        passed,
    output logic [31:0] fail_address,
    output logic [31:0] fail_data
);
    import mpts_pkg::*;

    logic [31:0] base_reg;
    logic [31:0] start_reg;
    logic [31:0] end_reg;
    logic        order_reg;
    logic [4:0]  shift_reg;

    logic        in_valid_reg;
    logic        cmd_reg;
    logic [31:0] rdata_reg;

    seq_state_t  st_reg;
    seq_state_t  st_next;
    logic        fail_seen_reg;
    logic        fail_seen_next;
    logic [31:0] fail_addr_reg;
    logic [31:0] fail_addr_next;
    logic [31:0] fail_data_reg;
    logic [31:0] fail_data_next;

    logic        out_valid_reg;
    logic        acc_reg;
    logic        wr_reg;
    logic        byte_reg;
    logic [31:0] addr_reg;
    logic [31:0] wdata_reg;
    logic [2:0]  phase_reg;
    logic        mark_reg;
    logic        done_reg;
    logic        pass_reg;
    logic [31:0] faddr_out_reg;
    logic [31:0] fdata_out_reg;

    logic        acc_next;
    logic        wr_next;
    logic        byte_next;
    logic [31:0] addr_next;
    logic [31:0] wdata_next;
    logic        mark_next;

    logic        advance;
    logic [2:0]  count;
    seq_state_t  st_pre;
    seq_state_t  st_step;
    kind_t       chk_kind;
    kind_t       out_kind;
    logic [31:0] chk_addr;
    logic [31:0] expect_word;
    logic        chk_read;
    logic [31:0] mark_mask;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign count    = (order_reg == ORDER_SRAM) ? SRAM_PHASES : DDR_PHASES;

    always_comb
    begin
        st_pre         = settle(st_reg, start_reg, end_reg, count);
        st_step        = st_reg;
        fail_seen_next = fail_seen_reg;
        fail_addr_next = fail_addr_reg;
        fail_data_next = fail_data_reg;
        chk_kind       = kind_of(order_reg, st_pre.phase);
        chk_addr       = base_reg + st_pre.offset;
        chk_read       = (chk_kind == K_RPAT) || (chk_kind == K_RBYTE) ||
                         (chk_kind == K_RADDR);
        if (chk_kind == K_RPAT)
        begin
            expect_word = PAT_WORD;
        end
        else if (chk_kind == K_RBYTE)
        begin
            expect_word = PAT_MERGED;
        end
        else
        begin
            expect_word = chk_addr;
        end

        if (cmd_reg == CMD_START)
        begin
            st_step.phase    = 3'd0;
            st_step.offset   = start_reg;
            st_step.running  = 1'b1;
            st_step.finished = 1'b0;
            fail_seen_next   = 1'b0;
            fail_addr_next   = '0;
            fail_data_next   = '0;
        end
        else if (st_reg.running)
        begin
            st_step = st_pre;
            if (st_pre.running)
            begin
                if (chk_read && rdata_reg != expect_word)
                begin
                    fail_seen_next = 1'b1;
                    fail_addr_next = chk_addr;
                    fail_data_next = rdata_reg;
                    st_step.phase  = st_pre.phase + 3'd1;
                    st_step.offset = start_reg;
                end
                else if (&st_pre.offset[31:2])
                begin
                    st_step.phase  = st_pre.phase + 3'd1;
                    st_step.offset = start_reg;
                end
                else
                begin
                    st_step.offset = st_pre.offset + 32'd4;
                end
            end
        end

        st_next   = settle(st_step, start_reg, end_reg, count);
        out_kind  = kind_of(order_reg, st_next.phase);
        mark_mask = (32'd1 << shift_reg) - 32'd1;

        acc_next   = st_next.running;
        wr_next    = 1'b0;
        byte_next  = 1'b0;
        addr_next  = '0;
        wdata_next = '0;
        mark_next  = 1'b0;
        if (st_next.running)
        begin
            addr_next = base_reg + st_next.offset;
            wr_next   = (out_kind == K_WPAT) || (out_kind == K_WBYTE) ||
                        (out_kind == K_WADDR);
            byte_next = (out_kind == K_WBYTE);
            mark_next = ((st_next.offset & mark_mask) == 32'd0);
            case (out_kind)
                K_WPAT:  wdata_next = PAT_WORD;
                K_WBYTE: wdata_next = PAT_BYTE;
                K_WADDR: wdata_next = addr_next;
                default: wdata_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= BASE_RESET;
            start_reg     <= START_RESET;
            end_reg       <= END_RESET;
            order_reg     <= ORDER_RESET;
            shift_reg     <= SHIFT_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
            fail_seen_reg <= 1'b0;
            fail_addr_reg <= '0;
            fail_data_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BASE:  base_reg  <= cfg_data;
                    CFG_START: start_reg <= cfg_data;
                    CFG_END:   end_reg   <= cfg_data;
                    CFG_ORDER: order_reg <= cfg_data[0];
                    CFG_SHIFT: shift_reg <= cfg_data[4:0];
                    default:   ;
                endcase
            end

            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
                fail_seen_reg <= fail_seen_next;
                fail_addr_reg <= fail_addr_next;
                fail_data_reg <= fail_data_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg   <= cmd;
            rdata_reg <= read_data;
        end
        if (advance)
        begin
            acc_reg       <= acc_next;
            wr_reg        <= wr_next;
            byte_reg      <= byte_next;
            addr_reg      <= addr_next;
            wdata_reg     <= wdata_next;
            phase_reg     <= st_next.running ? st_next.phase : 3'd0;
            mark_reg      <= mark_next;
            done_reg      <= st_next.finished;
            pass_reg      <= st_next.finished && !fail_seen_next;
            faddr_out_reg <= fail_addr_next;
            fdata_out_reg <= fail_data_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign access_valid  = acc_reg;
    assign is_write      = wr_reg;
    assign byte_only     = byte_reg;
    assign address       = addr_reg;
    assign write_data    = wdata_reg;
    assign phase         = phase_reg;
    assign progress_mark = mark_reg;
    assign done_res      = done_reg;
    assign passed        = pass_reg;
    assign fail_address  = faddr_out_reg;
    assign fail_data     = fdata_out_reg;

    // A test is never both running and finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(st_reg.running && st_reg.finished))
        else $error("sequencer both running and finished");

    // A result never describes an access and a verdict at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(acc_reg && done_reg))
        else $error("access issued after test finished");

    // A pass verdict needs a finished test and a clean fail record.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && pass_reg) |-> (done_reg && faddr_out_reg == 32'd0 &&
                                         fdata_out_reg == 32'd0))
        else $error("pass reported with a fail record");

    // A byte access is always a write.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && byte_reg) |-> wr_reg)
        else $error("byte lane read issued");

    // An item held in the input register stays until it is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input item lost");

endmodule

/* tb/memory_pattern_test_sequencer_tb.sv */
module memory_pattern_test_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpts_pkg::*;

    localparam logic CMD_DONE     = 1'b1;
    localparam logic ORDER_DDR    = 1'b1;
    localparam int   STALL_LIMIT  = 3000;
    localparam int   DRAIN_CYCLES = 8;
    localparam int   HOLD_CYCLES  = 400;

    typedef struct {
        logic        access_valid;
        logic        is_write;
        logic        byte_only;
        logic [31:0] address;
        logic [31:0] write_data;
        logic [2:0]  phase;
        logic        progress_mark;
        logic        done_res;
        logic        passed;
        logic [31:0] fail_address;
        logic [31:0] fail_data;
    } seq_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = CFG_BASE;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        cmd = CMD_START;
    logic [31:0] read_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        access_valid;
    logic        is_write;
    logic        byte_only;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [2:0]  phase;
    logic        progress_mark;
    logic        done_res;
    logic        passed;
    logic [31:0] fail_address;
    logic [31:0] fail_data;

    seq_report_t awaited_reports[$];
    int          mismatch_count = 0;
    int          send_idle_pct = 30;
    int          recv_idle_pct = 55;
    int          ready_hold = 0;

    logic [31:0] reg_base = BASE_RESET;
    logic [31:0] reg_start = START_RESET;
    logic [31:0] reg_end = END_RESET;
    logic        reg_order = ORDER_RESET;
    logic [4:0]  reg_shift = SHIFT_RESET;

    logic [2:0]  cur_phase = '0;
    logic [31:0] cur_offset = '0;
    logic        test_running = 1'b0;
    logic        test_finished = 1'b0;
    logic        fail_flag = 1'b0;
    logic [31:0] fail_addr_rec = '0;
    logic [31:0] fail_data_rec = '0;

    memory_pattern_test_sequencer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .read_data     (read_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .access_valid  (access_valid),
        .is_write      (is_write),
        .byte_only     (byte_only),
        .address       (address),
        .write_data    (write_data),
        .phase         (phase),
        .progress_mark (progress_mark),
        .done_res      (done_res),
        .passed        (passed),
        .fail_address  (fail_address),
        .fail_data     (fail_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic kind_t phase_kind(logic order, logic [2:0] ph);
        kind_t k;
        k = K_RPAT;
        if (order == ORDER_SRAM)
        begin
            case (ph)
                3'd0: k = K_WPAT;
                3'd1: k = K_RPAT;
                3'd2: k = K_WBYTE;
                3'd3: k = K_RBYTE;
                3'd4: k = K_WADDR;
                3'd5: k = K_RADDR;
                default: k = K_RPAT;
            endcase
        end
        else
        begin
            case (ph)
                3'd0: k = K_WADDR;
                3'd1: k = K_RADDR;
                3'd2: k = K_WPAT;
                3'd3: k = K_WBYTE;
                default: k = K_RBYTE;
            endcase
        end
        return k;
    endfunction

    function automatic logic reads_back(kind_t k);
        return (k == K_RPAT) || (k == K_RBYTE) || (k == K_RADDR);
    endfunction

    function automatic logic [31:0] read_pattern(kind_t k, logic [31:0] addr);
        if (k == K_RPAT)
            return PAT_WORD;
        if (k == K_RBYTE)
            return PAT_MERGED;
        return addr;
    endfunction

    function automatic void start_next_phase();
        cur_phase = cur_phase + 3'd1;
        cur_offset = reg_start;
    endfunction

    function automatic void end_test();
        test_running = 1'b0;
        test_finished = 1'b1;
    endfunction

    function automatic void skip_spent_phases();
        int guard;
        for (guard = 0; guard < 8; guard++)
        begin
            if (!test_running)
                return;
            if (cur_phase >= ((reg_order == ORDER_SRAM) ? SRAM_PHASES : DDR_PHASES))
                end_test();
            else if (cur_offset >= reg_end)
                start_next_phase();
            else
                return;
        end
        if (test_running)
            end_test();
    endfunction

    function automatic void advance_sequencer(logic c, logic [31:0] rd);
        kind_t       k;
        logic [31:0] addr;
        logic [31:0] mask;
        logic [32:0] stepped;
        seq_report_t rep;
        if (c == CMD_START)
        begin
            cur_phase = '0;
            cur_offset = reg_start;
            test_running = 1'b1;
            test_finished = 1'b0;
            fail_flag = 1'b0;
            fail_addr_rec = '0;
            fail_data_rec = '0;
        end
        else if (test_running)
        begin
            skip_spent_phases();
            if (test_running)
            begin
                k = phase_kind(reg_order, cur_phase);
                addr = reg_base + cur_offset;
                if (reads_back(k) && rd != read_pattern(k, addr))
                begin
                    fail_flag = 1'b1;
                    fail_addr_rec = addr;
                    fail_data_rec = rd;
                    start_next_phase();
                end
                else
                begin
                    stepped = {1'b0, cur_offset} + 33'd4;
                    if (stepped[32])
                        start_next_phase();
                    else
                        cur_offset = stepped[31:0];
                end
            end
        end
        skip_spent_phases();

        rep.access_valid = test_running;
        rep.is_write = 1'b0;
        rep.byte_only = 1'b0;
        rep.address = '0;
        rep.write_data = '0;
        rep.phase = '0;
        rep.progress_mark = 1'b0;
        if (test_running)
        begin
            k = phase_kind(reg_order, cur_phase);
            addr = reg_base + cur_offset;
            mask = (32'd1 << reg_shift) - 32'd1;
            rep.is_write = !reads_back(k);
            rep.byte_only = (k == K_WBYTE);
            rep.address = addr;
            if (k == K_WPAT)
                rep.write_data = PAT_WORD;
            else if (k == K_WBYTE)
                rep.write_data = PAT_BYTE;
            else if (k == K_WADDR)
                rep.write_data = addr;
            rep.phase = cur_phase;
            rep.progress_mark = ((cur_offset & mask) == 32'd0);
        end
        rep.done_res = test_finished;
        rep.passed = test_finished && !fail_flag;
        rep.fail_address = fail_addr_rec;
        rep.fail_data = fail_data_rec;
        awaited_reports.push_back(rep);
    endfunction

    function automatic logic [31:0] completion_data(bit corrupt);
        kind_t       k;
        logic [31:0] good;
        k = phase_kind(reg_order, cur_phase);
        if (!test_running || !reads_back(k))
            return $urandom;
        good = read_pattern(k, reg_base + cur_offset);
        if (!corrupt)
            return good;
        if ($urandom_range(1) == 1)
            return good ^ (32'd1 << $urandom_range(31));
        return $urandom;
    endfunction

    task automatic send_item(input logic c, input logic [31:0] rd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        cmd <= c;
        read_data <= rd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        advance_sequencer(c, rd);
    endtask

    task automatic complete_access(input bit corrupt);
        send_item(CMD_DONE, completion_data(corrupt));
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BASE:  reg_base = value;
            CFG_START: reg_start = value;
            CFG_END:   reg_end = value;
            CFG_ORDER: reg_order = value[0];
            CFG_SHIFT: reg_shift = value[4:0];
            default:   ;
        endcase
    endtask

    task automatic write_setup(input logic [31:0] base, input logic [31:0] first,
                               input logic [31:0] stop, input logic order,
                               input logic [4:0] shift);
        wait_drain();
        write_reg(CFG_BASE, base);
        write_reg(CFG_START, first);
        write_reg(CFG_END, stop);
        write_reg(CFG_ORDER, {31'd0, order});
        write_reg(CFG_SHIFT, {27'd0, shift});
    endtask

    task automatic random_setup();
        logic [31:0] base;
        logic [31:0] first;
        logic [31:0] stop;
        logic [4:0]  shift;
        int          words;
        words = $urandom_range(1, 6);
        case ($urandom_range(9))
            0:
            begin
                first = $urandom;
                if (first > 32'hFFFF_FF00)
                    first = 32'hFFFF_FF00;
                stop = first + 4 * words;
            end
            1:
            begin
                stop = 32'hFFFF_FFFC;
                first = stop - 4 * words;
            end
            2:
            begin
                first = 4 * $urandom_range(0, 8);
                stop = $urandom_range(0, first);
            end
            default:
            begin
                first = 4 * $urandom_range(0, 64);
                stop = first + 4 * words;
            end
        endcase
        if ($urandom_range(3) == 0)
            base = ($urandom_range(1) == 1) ? 32'hFFFF_FFFF : 32'd0;
        else
            base = $urandom;
        if ($urandom_range(3) == 0)
            shift = 5'($urandom_range(0, 31));
        else
            shift = 5'($urandom_range(2, 5));
        write_setup(base, first, stop, 1'($urandom_range(1)), shift);
    endtask

    task automatic test_idle_and_defaults();
        complete_access(1'b0);
        send_item(CMD_START, $urandom);
        complete_access(1'b0);
        complete_access(1'b0);
        send_item(CMD_START, 32'hFFFF_FFFF);
        complete_access(1'b0);
    endtask

    task automatic test_sram_wrapped_address();
        write_setup(32'hFFFF_FFF0, 32'h0000_0014, 32'h0000_0018, ORDER_SRAM, 5'd0);
        send_item(CMD_START, 32'd0);
        repeat (6) complete_access(1'b0);
    endtask

    task automatic test_ddr_offset_wrap();
        write_setup(32'd0, 32'hFFFF_FFFA, 32'hFFFF_FFFF, ORDER_DDR, 5'd31);
        send_item(CMD_START, 32'd0);
        repeat (2) complete_access(1'b0);
        complete_access(1'b1);
        repeat (6) complete_access(1'b0);
        complete_access(1'b0);
    endtask

    task automatic test_empty_range();
        write_setup(32'h1234_5678, 32'h0000_0100, 32'h0000_0100, ORDER_SRAM, 5'd1);
        send_item(CMD_START, 32'd0);
    endtask

    task automatic test_random_traffic(input int n_items, input int send_pct,
                                       input int recv_pct, input bit with_hold);
        int i;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        random_setup();
        for (i = 0; i < n_items; i++)
        begin
            if (with_hold && i == n_items / 2)
                ready_hold = HOLD_CYCLES;
            // Reconfiguring here often lands in the middle of a running test.
            if (i % 70 == 69)
                random_setup();
            if (!test_running)
            begin
                if ($urandom_range(9) < 8)
                    send_item(CMD_START, $urandom);
                else
                    complete_access(1'b0);
            end
            else if ($urandom_range(99) < 3)
                send_item(CMD_START, $urandom);
            else
                complete_access($urandom_range(99) < 6);
        end
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (ready_hold > 0)
            begin
                out_ready <= 1'b0;
                ready_hold = ready_hold - 1;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        seq_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_reports.size() == 0)
            begin
                $error("result transfer with no prediction pending");
                mismatch_count++;
            end
            else
            begin
                want = awaited_reports.pop_front();
                compare_field("access_valid", 32'(want.access_valid), 32'(access_valid));
                compare_field("is_write", 32'(want.is_write), 32'(is_write));
                compare_field("byte_only", 32'(want.byte_only), 32'(byte_only));
                compare_field("address", want.address, address);
                compare_field("write_data", want.write_data, write_data);
                compare_field("phase", 32'(want.phase), 32'(phase));
                compare_field("progress_mark", 32'(want.progress_mark),
                              32'(progress_mark));
                compare_field("done_res", 32'(want.done_res), 32'(done_res));
                compare_field("passed", 32'(want.passed), 32'(passed));
                compare_field("fail_address", want.fail_address, fail_address);
                compare_field("fail_data", want.fail_data, fail_data);
            end
        end
    end

    initial
    begin : watchdog
        int stale;
        stale = 0;
        while (stale < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stale = 0;
            else
                stale++;
        end
        $display("memory_pattern_test_sequencer_tb: done, errors");
        $finish;
    end

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        test_idle_and_defaults();
        test_sram_wrapped_address();
        test_ddr_offset_wrap();
        test_empty_range();
        test_random_traffic(280, 30, 55, 1'b0);
        test_random_traffic(280, 55, 30, 1'b1);
        test_random_traffic(270, 0, 0, 1'b0);
        wait_drain();
        if (mismatch_count == 0)
            $display("memory_pattern_test_sequencer_tb: done, clean");
        else
            $display("memory_pattern_test_sequencer_tb: done, errors");
        $finish;
    end

endmodule

/* sim.f */
hdl/mpts_pkg.sv
hdl/memory_pattern_test_sequencer.sv
tb/memory_pattern_test_sequencer_tb.sv
